@@ src/ffwp_pkg.sv @@
// Shared types and constants for the frame FIFO with peak tracking.
package ffwp_pkg;

	localparam int WORD_BITS  = 32;
	localparam int MAX_FRAMES = 16;
	localparam int SLOT_W     = 4;
	localparam int COUNT_W    = 5;
	localparam int WORDS_W    = 7;
	localparam int CAP_W      = 5;
	localparam int CFG_W      = 7;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_UNUSED   = 2'd3
	} status_t;

	typedef enum logic {
		REG_FRAME_WORDS = 1'b0,
		REG_RING_SLOTS  = 1'b1
	} reg_index_t;

	localparam logic [WORDS_W-1:0] FRAME_WORDS_RESET = 7'd64;
	localparam logic [CAP_W-1:0]   RING_SLOTS_RESET  = 5'd16;

endpackage

@@ src/frame_fifo_with_peak.sv @@
// Frame FIFO top level: ring of fixed-size frames in one synchronous memory.
//
// Input channel (in_valid / in_stall, operation, write_data) carries one
// operation per beat: write one word, read one word, clear the ring, or none.
// Output channel (out_valid / out_stall) returns exactly one result beat per
// input beat, in order: status, read_data, last_word, frames_held, frames_peak.
// The result of a beat is registered at the edge that accepts it and shows in
// the cycle after. Throughput is one beat per cycle while out_stall holds no
// result, set by the single memory port that a write or read beat uses once.
// Frames are committed after their last word; a frame whose first word finds
// the ring at capacity is dropped whole with a no-space status on every word.
// Configuration (frame_words, ring slot limit) is written through cfg_write, cfg_index and
// cfg_data; the user must write it only while no beat is in flight, the block does not enforce it.
// Reset clears pointers, counts, peak and configuration to 64 words and 16
// frames; the frame memory holds garbage until written and needs no sweep.
// While out_stall holds a result, in_stall is raised and the result holds.
module frame_fifo_with_peak #(
	parameter int MAX_FRAME_WORDS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic                          cfg_index,
	input  logic [ffwp_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    operation,
	input  logic [ffwp_pkg::WORD_BITS-1:0] write_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [ffwp_pkg::WORD_BITS-1:0] read_data,
	output logic                          last_word,
	output logic [ffwp_pkg::COUNT_W-1:0]  frames_held,
	output logic [ffwp_pkg::COUNT_W-1:0]  frames_peak
);

	localparam int OFS_W   = (MAX_FRAME_WORDS > 1) ? $clog2(MAX_FRAME_WORDS) : 1;
	localparam int LEN_W   = ((OFS_W > ffwp_pkg::WORDS_W) ? OFS_W : ffwp_pkg::WORDS_W) + 1;
	localparam int ADDR_W  = ffwp_pkg::SLOT_W + OFS_W;
	localparam int DEPTH   = 2 ** ADDR_W;
	localparam int SLOT_W  = ffwp_pkg::SLOT_W;
	localparam int COUNT_W = ffwp_pkg::COUNT_W;
	localparam int CAP_W   = ffwp_pkg::CAP_W;

	logic [ffwp_pkg::WORDS_W-1:0] frame_words_q;
	logic [CAP_W-1:0]             ring_slots_q;

	logic [SLOT_W-1:0]  write_slot_q, read_slot_q;
	logic [OFS_W-1:0]   write_offset_q, read_offset_q;
	logic [COUNT_W-1:0] held_q, peak_q;
	logic               dropping_q;

	logic               out_valid_q;
	ffwp_pkg::status_t  status_q;
	logic               last_q;
	logic               rd_ok_q;
	logic [ffwp_pkg::WORD_BITS-1:0] rdata_q;

	logic [ffwp_pkg::WORD_BITS-1:0] mem [DEPTH];

	logic               accept;
	ffwp_pkg::op_t      op;
	logic [LEN_W-1:0]   words;
	logic [LEN_W-1:0]   fw_ext;
	logic [CAP_W-1:0]   cap;
	logic               wr_ends, rd_ends, drop;
	logic               mem_we, mem_re;
	logic [ADDR_W-1:0]  waddr, raddr;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot,
			input logic [CAP_W-1:0] limit);
		logic [CAP_W-1:0] n;
		n = CAP_W'(slot) + CAP_W'(1);
		return (n >= limit) ? '0 : n[SLOT_W-1:0];
	endfunction

	assign accept   = in_valid && !in_stall;
	assign in_stall = out_valid_q && out_stall;
	assign op       = ffwp_pkg::op_t'(operation);

	assign fw_ext = LEN_W'(frame_words_q);
	always_comb begin
		if (fw_ext == '0) begin
			words = LEN_W'(1);
		end else if (fw_ext > LEN_W'(MAX_FRAME_WORDS)) begin
			words = LEN_W'(MAX_FRAME_WORDS);
		end else begin
			words = fw_ext;
		end
		if (ring_slots_q == '0) begin
			cap = CAP_W'(1);
		end else if (ring_slots_q > CAP_W'(ffwp_pkg::MAX_FRAMES)) begin
			cap = CAP_W'(ffwp_pkg::MAX_FRAMES);
		end else begin
			cap = ring_slots_q;
		end
	end

	assign wr_ends = (LEN_W'(write_offset_q) + LEN_W'(1)) >= words;
	assign rd_ends = (LEN_W'(read_offset_q) + LEN_W'(1)) >= words;
	assign drop    = (write_offset_q == '0) ? (held_q >= cap) : dropping_q;
	assign waddr   = {write_slot_q, write_offset_q};
	assign raddr   = {read_slot_q, read_offset_q};
	assign mem_we  = accept && (op == ffwp_pkg::OP_WRITE) && !drop;
	assign mem_re  = accept && (op == ffwp_pkg::OP_READ) && (held_q != '0);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= write_data;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_words_q <= ffwp_pkg::FRAME_WORDS_RESET;
			ring_slots_q  <= ffwp_pkg::RING_SLOTS_RESET;
		end else if (cfg_write) begin
			unique case (ffwp_pkg::reg_index_t'(cfg_index))
				ffwp_pkg::REG_FRAME_WORDS: frame_words_q <= cfg_data;
				ffwp_pkg::REG_RING_SLOTS:  ring_slots_q  <= cfg_data[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q   <= '0;
			read_slot_q    <= '0;
			write_offset_q <= '0;
			read_offset_q  <= '0;
			held_q         <= '0;
			peak_q         <= '0;
			dropping_q     <= 1'b0;
			out_valid_q    <= 1'b0;
			status_q       <= ffwp_pkg::ST_OK;
			last_q         <= 1'b0;
			rd_ok_q        <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				unique case (op)
					ffwp_pkg::OP_WRITE: begin
						if (drop) begin
							status_q <= ffwp_pkg::ST_NO_SPACE;
						end else begin
							status_q <= ffwp_pkg::ST_OK;
						end
						last_q  <= wr_ends;
						rd_ok_q <= 1'b0;
						if (wr_ends) begin
							write_offset_q <= '0;
							dropping_q     <= 1'b0;
							if (!drop) begin
								write_slot_q <= next_slot(write_slot_q, cap);
								held_q       <= held_q + COUNT_W'(1);
								if ((held_q + COUNT_W'(1)) > peak_q) begin
									peak_q <= held_q + COUNT_W'(1);
								end
							end
						end else begin
							write_offset_q <= write_offset_q + OFS_W'(1);
							dropping_q     <= drop;
						end
					end
					ffwp_pkg::OP_READ: begin
						if (held_q == '0) begin
							status_q <= ffwp_pkg::ST_EMPTY;
							last_q   <= 1'b0;
							rd_ok_q  <= 1'b0;
						end else begin
							status_q <= ffwp_pkg::ST_OK;
							last_q   <= rd_ends;
							rd_ok_q  <= 1'b1;
							if (rd_ends) begin
								read_offset_q <= '0;
								read_slot_q   <= next_slot(read_slot_q, cap);
								held_q        <= held_q - COUNT_W'(1);
							end else begin
								read_offset_q <= read_offset_q + OFS_W'(1);
							end
						end
					end
					ffwp_pkg::OP_CLEAR: begin
						status_q       <= ffwp_pkg::ST_OK;
						last_q         <= 1'b0;
						rd_ok_q        <= 1'b0;
						write_slot_q   <= '0;
						read_slot_q    <= '0;
						write_offset_q <= '0;
						read_offset_q  <= '0;
						held_q         <= '0;
						peak_q         <= '0;
						dropping_q     <= 1'b0;
					end
					ffwp_pkg::OP_NONE: begin
						status_q <= ffwp_pkg::ST_OK;
						last_q   <= 1'b0;
						rd_ok_q  <= 1'b0;
					end
					default: ;
				endcase
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_data   = rd_ok_q ? rdata_q : '0;
	assign last_word   = last_q;
	assign frames_held = held_q;
	assign frames_peak = peak_q;

endmodule

@@ src/ffwp_checker.sv @@
// Port-level checker for the frame FIFO, bound to the top level.
module ffwp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [1:0]                     status,
	input logic [ffwp_pkg::WORD_BITS-1:0] read_data,
	input logic                           last_word,
	input logic [ffwp_pkg::COUNT_W-1:0]   frames_held,
	input logic [ffwp_pkg::COUNT_W-1:0]   frames_peak
);

	a_one_cycle_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted beat gave no result on the next cycle");

	a_peak_covers_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frames_peak >= frames_held))
		else $error("peak count below frame count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frames_held <= 5'(ffwp_pkg::MAX_FRAMES)))
		else $error("frame count above ring size");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ffwp_pkg::ST_EMPTY)) |->
		((frames_held == '0) && (read_data == '0) && !last_word))
		else $error("empty read result carries data or a nonzero count");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(read_data) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind frame_fifo_with_peak ffwp_checker u_ffwp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.read_data   (read_data),
	.last_word   (last_word),
	.frames_held (frames_held),
	.frames_peak (frames_peak)
);

@@ sim/ring_scoreboard_pkg.sv @@
// Scoreboard for the frame FIFO: predicts every result beat and checks the DUT against it.
`timescale 1ns / 100ps
package ring_scoreboard_pkg;

	localparam int WORD_BITS       = ffwp_pkg::WORD_BITS;
	localparam int COUNT_W         = ffwp_pkg::COUNT_W;
	localparam int CFG_W           = ffwp_pkg::CFG_W;
	localparam int CAP_W           = ffwp_pkg::CAP_W;
	localparam int MAX_FRAMES      = ffwp_pkg::MAX_FRAMES;
	localparam int FRAME_WORDS_MAX = 64;
	localparam int STORE_DEPTH     = MAX_FRAMES * FRAME_WORDS_MAX;

	typedef struct {
		logic [1:0]           status;
		logic [WORD_BITS-1:0] read_data;
		logic                 last_word;
		logic [COUNT_W-1:0]   frames_held;
		logic [COUNT_W-1:0]   frames_peak;
	} ring_result_t;

	class ring_scoreboard;
		logic [WORD_BITS-1:0] store [STORE_DEPTH];
		bit                   written [STORE_DEPTH];
		int unsigned          words_reg;
		int unsigned          capacity_reg;
		int unsigned          wr_slot;
		int unsigned          rd_slot;
		int unsigned          wr_off;
		int unsigned          rd_off;
		int unsigned          held;
		int unsigned          peak;
		bit                   dropping;
		ring_result_t         due_results [$];
		int unsigned          errors;

		function new();
			words_reg    = 32'(ffwp_pkg::FRAME_WORDS_RESET);
			capacity_reg = 32'(ffwp_pkg::RING_SLOTS_RESET);
			errors       = 0;
			empty_ring();
		endfunction

		function void empty_ring();
			wr_slot  = 0;
			rd_slot  = 0;
			wr_off   = 0;
			rd_off   = 0;
			held     = 0;
			peak     = 0;
			dropping = 1'b0;
		endfunction

		function int unsigned frame_len();
			if (words_reg == 0) return 1;
			if (words_reg > FRAME_WORDS_MAX) return FRAME_WORDS_MAX;
			return words_reg;
		endfunction

		function int unsigned frame_limit();
			if (capacity_reg == 0) return 1;
			if (capacity_reg > MAX_FRAMES) return MAX_FRAMES;
			return capacity_reg;
		endfunction

		function int unsigned slot_after(int unsigned slot);
			return (slot + 1 >= frame_limit()) ? 0 : slot + 1;
		endfunction

		function int unsigned word_index(int unsigned slot, int unsigned offset);
			return (slot % MAX_FRAMES) * FRAME_WORDS_MAX + (offset % FRAME_WORDS_MAX);
		endfunction

		function void set_reg(ffwp_pkg::reg_index_t idx, logic [CFG_W-1:0] value);
			if (idx == ffwp_pkg::REG_FRAME_WORDS) begin
				words_reg = 32'(value);
			end else begin
				capacity_reg = 32'(value[CAP_W-1:0]);
			end
		endfunction

		// a read of a never-written word is off limits
		function bit read_defined();
			return held == 0 || written[word_index(rd_slot, rd_off)];
		endfunction

		function int unsigned outstanding();
			return due_results.size();
		endfunction

		function void apply_beat(ffwp_pkg::op_t op, logic [WORD_BITS-1:0] data);
			ring_result_t r;
			int unsigned  words;
			bit           ends;
			words       = frame_len();
			r.status    = ffwp_pkg::ST_OK;
			r.read_data = '0;
			r.last_word = 1'b0;
			case (op)
				ffwp_pkg::OP_WRITE: begin
					ends = (wr_off + 1 >= words);
					if (wr_off == 0) dropping = (held >= frame_limit());
					if (dropping) begin
						r.status = ffwp_pkg::ST_NO_SPACE;
					end else begin
						store[word_index(wr_slot, wr_off)]   = data;
						written[word_index(wr_slot, wr_off)] = 1'b1;
					end
					if (ends) begin
						r.last_word = 1'b1;
						wr_off      = 0;
						if (!dropping) begin
							wr_slot = slot_after(wr_slot);
							held++;
							if (held > peak) peak = held;
						end
						dropping = 1'b0;
					end else begin
						wr_off++;
					end
				end
				ffwp_pkg::OP_READ: begin
					if (held == 0) begin
						r.status = ffwp_pkg::ST_EMPTY;
					end else begin
						r.read_data = store[word_index(rd_slot, rd_off)];
						if (rd_off + 1 >= words) begin
							r.last_word = 1'b1;
							rd_off      = 0;
							rd_slot     = slot_after(rd_slot);
							held--;
						end else begin
							rd_off++;
						end
					end
				end
				ffwp_pkg::OP_CLEAR: begin
					empty_ring();
				end
				default: begin
				end
			endcase
			r.frames_held = COUNT_W'(held);
			r.frames_peak = COUNT_W'(peak);
			due_results.push_back(r);
		endfunction

		function void field_matches(string name, logic [WORD_BITS-1:0] want,
				logic [WORD_BITS-1:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(ring_result_t got);
			ring_result_t want;
			if (due_results.size() == 0) begin
				$error("result beat with no expectation waiting: status %0d data 0x%0h",
					got.status, got.read_data);
				errors++;
				return;
			end
			want = due_results.pop_front();
			field_matches("status", WORD_BITS'(want.status), WORD_BITS'(got.status));
			field_matches("read_data", want.read_data, got.read_data);
			field_matches("last_word", WORD_BITS'(want.last_word), WORD_BITS'(got.last_word));
			field_matches("frames_held", WORD_BITS'(want.frames_held),
				WORD_BITS'(got.frames_held));
			field_matches("frames_peak", WORD_BITS'(want.frames_peak),
				WORD_BITS'(got.frames_peak));
		endfunction
	endclass

endpackage

@@ sim/tb_frame_fifo_with_peak.sv @@
// Testbench top for the frame FIFO: directed and random beats with input gaps and output stalls.
`timescale 1ns / 100ps
module tb_frame_fifo_with_peak;

	localparam int WORD_BITS       = ffwp_pkg::WORD_BITS;
	localparam int COUNT_W         = ffwp_pkg::COUNT_W;
	localparam int CFG_W           = ffwp_pkg::CFG_W;
	localparam int RANDOM_ITEMS    = 380;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int WATCHDOG_LIMIT  = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_write;
	logic                 cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           operation;
	logic [WORD_BITS-1:0] write_data;
	logic                 out_valid;
	logic                 out_stall;
	logic [1:0]           status;
	logic [WORD_BITS-1:0] read_data;
	logic                 last_word;
	logic [COUNT_W-1:0]   frames_held;
	logic [COUNT_W-1:0]   frames_peak;

	ring_scoreboard_pkg::ring_scoreboard sb = new();
	ring_scoreboard_pkg::ring_result_t   beat_result;
	int unsigned    quiet_cycles = 0;
	bit             hold_off_req = 1'b0;
	bit             tx_idle_on = 1'b1;
	bit             rx_idle_on = 1'b1;

	frame_fifo_with_peak dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 92) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic idle_in(input int unsigned cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic send_beat(input ffwp_pkg::op_t op, input logic [WORD_BITS-1:0] data);
		in_valid   <= 1'b1;
		operation  <= op;
		write_data <= data;
		do @(posedge clk); while (in_stall);
		sb.apply_beat(op, data);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	task automatic write_config(input logic [CFG_W-1:0] words, input logic [CFG_W-1:0] cap);
		cfg_write <= 1'b1;
		cfg_index <= ffwp_pkg::REG_FRAME_WORDS;
		cfg_data  <= words;
		@(posedge clk);
		sb.set_reg(ffwp_pkg::REG_FRAME_WORDS, words);
		cfg_index <= ffwp_pkg::REG_RING_SLOTS;
		cfg_data  <= cap;
		@(posedge clk);
		sb.set_reg(ffwp_pkg::REG_RING_SLOTS, cap);
		cfg_write <= 1'b0;
	endtask

	initial begin : receiver
		int unsigned len;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			len = 0;
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				len = HOLD_OFF_CYCLES;
			end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
				len = pick_gap();
			end
			if (len != 0) begin
				out_stall <= 1'b1;
				repeat (len) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			beat_result.status      = status;
			beat_result.read_data   = read_data;
			beat_result.last_word   = last_word;
			beat_result.frames_held = frames_held;
			beat_result.frames_peak = frames_peak;
			sb.check_result(beat_result);
		end
		if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL frame_fifo_with_peak");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned      phase;
		int unsigned      beats;
		int unsigned      count;
		int unsigned      burst;
		int unsigned      sent;
		int unsigned      write_pct;
		int unsigned      r;
		logic [CFG_W-1:0] words_cfg;
		logic [CFG_W-1:0] cap_cfg;
		ffwp_pkg::op_t    op;
		ffwp_pkg::op_t    beat_op;

		arst_n     <= 1'b0;
		cfg_write  <= 1'b0;
		cfg_index  <= ffwp_pkg::REG_FRAME_WORDS;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		operation  <= ffwp_pkg::OP_NONE;
		write_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset config: empty read, unused op, partial frame, clear
		send_beat(ffwp_pkg::OP_READ, $urandom());
		send_beat(ffwp_pkg::OP_NONE, 32'hFFFF_FFFF);
		send_beat(ffwp_pkg::OP_WRITE, 32'hFFFF_FFFF);
		send_beat(ffwp_pkg::OP_CLEAR, $urandom());

		// one-frame ring: commit, drop a whole frame, drain, read empty
		drain_results();
		write_config(7'd2, 7'd1);
		send_beat(ffwp_pkg::OP_WRITE, 32'h0000_0000);
		send_beat(ffwp_pkg::OP_WRITE, 32'hFFFF_FFFF);
		send_beat(ffwp_pkg::OP_WRITE, 32'hA5A5_A5A5);
		send_beat(ffwp_pkg::OP_WRITE, 32'h5A5A_5A5A);
		send_beat(ffwp_pkg::OP_READ, $urandom());
		send_beat(ffwp_pkg::OP_READ, $urandom());
		send_beat(ffwp_pkg::OP_READ, $urandom());

		// hold one frame plus a partial one, then shrink both registers to zero
		drain_results();
		write_config(7'd3, 7'd2);
		send_beat(ffwp_pkg::OP_WRITE, 32'h0000_0001);
		send_beat(ffwp_pkg::OP_WRITE, 32'h0000_0002);
		send_beat(ffwp_pkg::OP_WRITE, 32'h0000_0003);
		send_beat(ffwp_pkg::OP_WRITE, 32'h0000_0004);
		send_beat(ffwp_pkg::OP_WRITE, 32'h0000_0005);
		drain_results();
		write_config(7'd0, 7'd0);
		send_beat(ffwp_pkg::OP_WRITE, 32'h0000_0006);
		send_beat(ffwp_pkg::OP_READ, $urandom());
		send_beat(ffwp_pkg::OP_WRITE, 32'h0000_0007);
		send_beat(ffwp_pkg::OP_READ, $urandom());
		send_beat(ffwp_pkg::OP_READ, $urandom());

		sent = 0;
		for (phase = 0; sent < RANDOM_ITEMS; phase++) begin
			drain_results();
			if (phase == 3) begin
				words_cfg = 7'd127;
				cap_cfg   = 7'd31;
				beats     = 130;
				write_pct = 55;
			end else if (phase == 7) begin
				words_cfg = 7'd64;
				cap_cfg   = 7'd1;
				beats     = 70;
				write_pct = 60;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 15) words_cfg = 7'd0;
				else if (r < 30) words_cfg = 7'd1;
				else words_cfg = CFG_W'($urandom_range(2, 6));
				r = $urandom_range(0, 99);
				if (r < 12) cap_cfg = 7'd0;
				else if (r < 25) cap_cfg = 7'd1;
				else if (r < 35) cap_cfg = 7'd31;
				else if (r < 50) cap_cfg = 7'd16;
				else cap_cfg = CFG_W'($urandom_range(2, 5));
				beats     = $urandom_range(25, 45);
				write_pct = $urandom_range(35, 65);
			end
			write_config(words_cfg, cap_cfg);
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			if (phase == 1) begin
				tx_idle_on   = 1'b0;
				hold_off_req = 1'b1;
			end

			count = 0;
			while (count < beats && sent < RANDOM_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < write_pct) op = ffwp_pkg::OP_WRITE;
				else if (r < 94) op = ffwp_pkg::OP_READ;
				else if (r < 97) op = ffwp_pkg::OP_CLEAR;
				else op = ffwp_pkg::OP_NONE;
				if (op == ffwp_pkg::OP_WRITE || op == ffwp_pkg::OP_READ)
					burst = $urandom_range(1, sb.frame_len());
				else
					burst = 1;
				repeat (burst) begin
					beat_op = op;
					if (op == ffwp_pkg::OP_READ && !sb.read_defined())
						beat_op = ffwp_pkg::OP_CLEAR;
					if (tx_idle_on && $urandom_range(0, 99) < 25) idle_in(pick_gap());
					send_beat(beat_op, $urandom());
					count++;
					if (beat_op != ffwp_pkg::OP_NONE) sent++;
				end
			end
		end

		drain_results();
		repeat (5) @(posedge clk);
		if (sb.errors == 0) begin
			$display("PASS frame_fifo_with_peak");
		end else begin
			$display("FAIL frame_fifo_with_peak");
		end
		$finish;
	end

endmodule
